>>> sv/plane_split_fragment_macros.svh
// Assertion macros shared by the plane split fragment RTL.
`ifndef PLANE_SPLIT_FRAGMENT_MACROS_SVH
`define PLANE_SPLIT_FRAGMENT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define PSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSF_ASSERT_IMP(lbl, ante, cons, msg)
`define PSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/psf_pkg.sv
// Shared constants, codes and types of the plane split fragment block.
`timescale 1ns / 1ps
package psf_pkg;

    localparam int CW      = 32;            // coordinate width, Q16.16
    localparam int NW      = 32;            // normal width, Q2.30
    localparam int NFRAC   = 30;            // fraction bits of the normal
    localparam int EPS_W   = 16;
    localparam int DIFF_W  = CW + 1;
    localparam int PROD_W  = NW + DIFF_W;
    localparam int DIST_W  = CW + 4;        // holds the sum of three terms
    localparam int MAG_W   = DIST_W;
    localparam int TW      = 32;            // cut ratio, Q0.32
    localparam int CNT_W   = $clog2(TW);
    localparam int QDEPTH  = 4;             // power of two
    localparam int QAW     = $clog2(QDEPTH);
    localparam int CFG_DW  = (CW > NW) ? CW : NW;
    localparam int CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] REG_NORMAL_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PLANE_X  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PLANE_Y  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PLANE_Z  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_EPSILON  = 3'd6;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_TRI   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [1:0] SIDE_FRONT = 2'd0;
    localparam logic [1:0] SIDE_BACK  = 2'd1;
    localparam logic [1:0] SIDE_ON    = 2'd2;

    // Source of one vertex slot of an emitted piece
    localparam logic [1:0] SEL_ORIG = 2'd0;
    localparam logic [1:0] SEL_X1   = 2'd1;
    localparam logic [1:0] SEL_X2   = 2'd2;
    localparam logic [1:0] SEL_ZERO = 2'd3;

    typedef logic signed [CW-1:0]     coord_t;
    typedef coord_t [2:0]             vtx_t;
    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic [1:0]               sel_t;

    typedef struct packed {
        logic [1:0]   side;
        sel_t [2:0]   sel;
    } piece_t;

    typedef struct packed {
        logic [1:0]   npieces;
        logic         ncut1;
        logic         ncut2;
        logic [1:0]   c1p;
        logic [1:0]   c1q;
        logic [1:0]   c2p;
        logic [1:0]   c2q;
        piece_t [2:0] pc;
    } psf_ctl_t;

    typedef struct packed {
        vtx_t [2:0]   v;
        dist_t [2:0]  d;
        psf_ctl_t     ctl;
    } psf_job_t;

endpackage

>>> sv/plane_split_fragment.sv
// Top level of the plane split fragment block.
`timescale 1ns / 1ps
// Classifies points, line segments and triangles against the configured plane
// and cuts crossing fragments into front and back pieces. A four-stage front
// pipe computes the vertex distances and classifies one fragment per cycle
// while the queue has room; a four-entry queue feeds the back end, which emits
// one piece per cycle while the output does not stall, so fragments that need
// no cut flow at one piece per cycle. Each cut point goes through a serial
// divider that makes one quotient bit per cycle: a crossing line or a triangle
// with one vertex on the plane needs one cut, a triangle with no vertex on the
// plane two cuts. Empty fragments are dropped in the front and give no output
// transfer.
module plane_split_fragment
    import psf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  coord_t            a_x,
    input  coord_t            a_y,
    input  coord_t            a_z,
    input  coord_t            b_x,
    input  coord_t            b_y,
    input  coord_t            b_z,
    input  coord_t            c_x,
    input  coord_t            c_y,
    input  coord_t            c_z,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        side,
    output coord_t            out_a_x,
    output coord_t            out_a_y,
    output coord_t            out_a_z,
    output coord_t            out_b_x,
    output coord_t            out_b_y,
    output coord_t            out_b_z,
    output coord_t            out_c_x,
    output coord_t            out_c_y,
    output coord_t            out_c_z,
    output logic              last_piece
);

    psf_job_t   wr_job, rd_job;
    logic       push, full, pop, empty;
    vtx_t [2:0] out_v;

    psf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .job       (wr_job),
        .push      (push),
        .full      (full)
    );

    psf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty)
    );

    psf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!empty),
        .job        (rd_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .side       (side),
        .out_v      (out_v),
        .last_piece (last_piece)
    );

    assign out_a_x = out_v[0][0];
    assign out_a_y = out_v[0][1];
    assign out_a_z = out_v[0][2];
    assign out_b_x = out_v[1][0];
    assign out_b_y = out_v[1][1];
    assign out_b_z = out_v[1][2];
    assign out_c_x = out_v[2][0];
    assign out_c_y = out_v[2][1];
    assign out_c_z = out_v[2][2];

endmodule

>>> sv/psf_front.sv
// Front end: plane registers, distance pipeline and fragment classification.
`timescale 1ns / 1ps
module psf_front
    import psf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  coord_t            a_x,
    input  coord_t            a_y,
    input  coord_t            a_z,
    input  coord_t            b_x,
    input  coord_t            b_y,
    input  coord_t            b_z,
    input  coord_t            c_x,
    input  coord_t            c_y,
    input  coord_t            c_z,
    output psf_job_t          job,
    output logic              push,
    input  logic              full
);

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam prod_t RND = prod_t'((1 << NFRAC) - 1);

    logic signed [NW-1:0] normal_reg [3];
    coord_t               plane_reg [3];
    logic [EPS_W-1:0]     eps_reg;

    vtx_t [2:0]   in_v;
    logic         en;

    logic         s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [1:0]   s1_kind_reg, s2_kind_reg, s3_kind_reg, s4_kind_reg;
    vtx_t [2:0]   s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    diff_t        s1_diff_reg [3][3];
    prod_t        s2_prod_reg [3][3];
    dist_t        s3_term_reg [3][3];
    dist_t [2:0]  s4_d_reg;
    logic [2:0]   s4_pos_reg, s4_neg_reg;

    dist_t        eps_s;
    prod_t        rnd_tmp [3][3];
    dist_t        dsum [3];

    function automatic logic [1:0] side_of(input logic p, input logic n);
        logic [1:0] s;
        s = p ? SIDE_FRONT : (n ? SIDE_BACK : SIDE_ON);
        return s;
    endfunction

    function automatic logic [1:0] nxt(input logic [1:0] i);
        logic [1:0] r;
        r = (i == 2'd2) ? 2'd0 : i + 2'd1;
        return r;
    endfunction

    function automatic psf_ctl_t classify(input logic [1:0] k, input logic [2:0] pos,
                                          input logic [2:0] neg);
        psf_ctl_t   c;
        logic [2:0] zer;
        logic [1:0] np, nn, nz;
        logic [1:0] i0, i1, i2;
        logic [1:0] lone, other;
        c = '0;
        zer = ~(pos | neg);
        np = {1'b0, pos[0]} + {1'b0, pos[1]} + {1'b0, pos[2]};
        nn = {1'b0, neg[0]} + {1'b0, neg[1]} + {1'b0, neg[2]};
        nz = {1'b0, zer[0]} + {1'b0, zer[1]} + {1'b0, zer[2]};
        for (int p = 0; p < 3; p++) begin
            c.pc[p].sel = {SEL_ORIG, SEL_ORIG, SEL_ORIG};
        end
        c.npieces = 2'd1;
        if (k == KIND_POINT) begin
            c.pc[0].side = side_of(pos[0], neg[0]);
            c.pc[0].sel  = {SEL_ZERO, SEL_ZERO, SEL_ORIG};
        end else if (k == KIND_LINE) begin
            c.pc[0].sel = {SEL_ZERO, SEL_ORIG, SEL_ORIG};
            c.pc[1].sel = {SEL_ZERO, SEL_ORIG, SEL_ORIG};
            if (zer[0] && zer[1]) begin
                c.pc[0].side = SIDE_ON;
            end else if (({1'b0, pos[0]} + {1'b0, pos[1]}) > ({1'b0, neg[0]} + {1'b0, neg[1]}))
            begin
                c.pc[0].side = SIDE_FRONT;
            end else if (({1'b0, pos[0]} + {1'b0, pos[1]}) < ({1'b0, neg[0]} + {1'b0, neg[1]}))
            begin
                c.pc[0].side = SIDE_BACK;
            end else begin
                c.npieces    = 2'd2;
                c.ncut1      = 1'b1;
                c.c1p        = 2'd0;
                c.c1q        = 2'd1;
                c.pc[0].side = SIDE_FRONT;
                c.pc[1].side = SIDE_BACK;
                if (neg[0]) begin
                    c.pc[0].sel[0] = SEL_X1;
                    c.pc[1].sel[1] = SEL_X1;
                end else begin
                    c.pc[0].sel[1] = SEL_X1;
                    c.pc[1].sel[0] = SEL_X1;
                end
            end
        end else begin
            if (nz == 2'd3) begin
                c.pc[0].side = SIDE_ON;
            end else if (nn == 2'd0) begin
                c.pc[0].side = SIDE_FRONT;
            end else if (np == 2'd0) begin
                c.pc[0].side = SIDE_BACK;
            end else if (nz == 2'd1) begin
                // one vertex on the plane: cut the opposite edge once
                i0 = zer[0] ? 2'd0 : (zer[1] ? 2'd1 : 2'd2);
                i1 = nxt(i0);
                i2 = nxt(i1);
                c.npieces       = 2'd2;
                c.ncut1         = 1'b1;
                c.c1p           = i1;
                c.c1q           = i2;
                c.pc[0].side    = side_of(pos[i1], neg[i1]);
                c.pc[0].sel[i2] = SEL_X1;
                c.pc[1].side    = side_of(pos[i2], neg[i2]);
                c.pc[1].sel[i1] = SEL_X1;
            end else begin
                // lone vertex against two on the other side
                i0 = (pos[1] == pos[2]) ? 2'd0 : ((pos[0] == pos[2]) ? 2'd1 : 2'd2);
                i1 = nxt(i0);
                i2 = nxt(i1);
                lone  = pos[i0] ? SIDE_FRONT : SIDE_BACK;
                other = pos[i0] ? SIDE_BACK : SIDE_FRONT;
                c.npieces       = 2'd3;
                c.ncut1         = 1'b1;
                c.ncut2         = 1'b1;
                c.c1p           = i0;
                c.c1q           = i1;
                c.c2p           = i0;
                c.c2q           = i2;
                c.pc[0].side    = lone;
                c.pc[0].sel[i1] = SEL_X1;
                c.pc[0].sel[i2] = SEL_X2;
                c.pc[1].side    = other;
                c.pc[1].sel[i0] = SEL_X1;
                c.pc[1].sel[i2] = SEL_X2;
                c.pc[2].side    = other;
                c.pc[2].sel[i0] = SEL_X2;
            end
        end
        return c;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NW'(1 << NFRAC);
            plane_reg[0]  <= '0;
            plane_reg[1]  <= '0;
            plane_reg[2]  <= '0;
            eps_reg       <= EPS_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NORMAL_X: normal_reg[0] <= cfg_data[NW-1:0];
                REG_NORMAL_Y: normal_reg[1] <= cfg_data[NW-1:0];
                REG_NORMAL_Z: normal_reg[2] <= cfg_data[NW-1:0];
                REG_PLANE_X:  plane_reg[0]  <= cfg_data[CW-1:0];
                REG_PLANE_Y:  plane_reg[1]  <= cfg_data[CW-1:0];
                REG_PLANE_Z:  plane_reg[2]  <= cfg_data[CW-1:0];
                REG_EPSILON:  eps_reg       <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_v[0] = {a_z, a_y, a_x};
    assign in_v[1] = {b_z, b_y, b_x};
    assign in_v[2] = {c_z, c_y, c_x};

    // hold the whole pipe while a fragment waits for room in the queue
    assign en       = !(s4_valid_reg && (s4_kind_reg != KIND_EMPTY) && full);
    assign in_stall = !en;
    assign push     = s4_valid_reg && (s4_kind_reg != KIND_EMPTY) && !full;

    assign eps_s = dist_t'(eps_reg);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_tmp[j][i] = s2_prod_reg[j][i]
                              + (s2_prod_reg[j][i][PROD_W-1] ? RND : prod_t'(0));
            end
            dsum[j] = s3_term_reg[j][0] + s3_term_reg[j][1] + s3_term_reg[j][2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg <= kind;
            s2_kind_reg <= s1_kind_reg;
            s3_kind_reg <= s2_kind_reg;
            s4_kind_reg <= s3_kind_reg;
            s1_v_reg    <= in_v;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s1_diff_reg[j][i] <= DIFF_W'($signed(in_v[j][i]))
                                       - DIFF_W'($signed(plane_reg[i]));
                    s2_prod_reg[j][i] <= PROD_W'($signed(normal_reg[i]))
                                       * PROD_W'($signed(s1_diff_reg[j][i]));
                    s3_term_reg[j][i] <= dist_t'(rnd_tmp[j][i] >>> NFRAC);
                end
                s4_d_reg[j]   <= dsum[j];
                s4_pos_reg[j] <= dsum[j] > eps_s;
                s4_neg_reg[j] <= dsum[j] < -eps_s;
            end
        end
    end

    assign job.v   = s4_v_reg;
    assign job.d   = s4_d_reg;
    assign job.ctl = classify(s4_kind_reg, s4_pos_reg, s4_neg_reg);

endmodule

>>> sv/psf_queue.sv
// Short job queue between the classifying front and the cutting back end.
`timescale 1ns / 1ps
`include "plane_split_fragment_macros.svh"
module psf_queue
    import psf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  psf_job_t wr_job,
    output logic     full,
    input  logic     pop,
    output psf_job_t rd_job,
    output logic     empty
);

    psf_job_t       mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   cnt_reg;

    assign full   = cnt_reg == (QAW+1)'(QDEPTH);
    assign empty  = cnt_reg == '0;
    assign rd_job = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    `PSF_ASSERT_IMP(a_no_overflow, push, !full, "push into a full queue")
    `PSF_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from an empty queue")
    `PSF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= (QAW+1)'(QDEPTH), "queue count past depth")

endmodule

>>> sv/psf_cut.sv
// Serial cut-point unit: restoring divide for the ratio, then scale and offset.
`timescale 1ns / 1ps
module psf_cut
    import psf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  vtx_t  p,
    input  vtx_t  q,
    input  dist_t dp,
    input  dist_t dq,
    output logic  done,
    output vtx_t  x
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_MUL  = 2'd2;
    localparam logic [1:0] PH_ADD  = 2'd3;

    logic [1:0]        phase_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  rem_reg, den_reg;
    logic [TW-1:0]     t_reg;
    vtx_t              p_reg, x_reg;
    logic [CW-1:0]     ad_reg [3];
    logic [2:0]        neg_reg;
    logic [CW+TW-1:0]  prod_reg [3];

    logic [MAG_W:0]    rem2;
    logic              ge;
    logic [MAG_W-1:0]  num_mag, dq_mag;
    logic signed [CW:0] dl [3];
    logic [CW-1:0]     off [3];
    logic [CW:0]       sum [3];

    function automatic logic [MAG_W-1:0] dmag(input dist_t v);
        logic [MAG_W-1:0] m;
        m = v[DIST_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return m;
    endfunction

    assign num_mag = dmag(dp);
    assign dq_mag  = dmag(dq);
    assign rem2    = {rem_reg, 1'b0};
    assign ge      = rem2 >= {1'b0, den_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dl[i]  = (CW+1)'($signed(q[i])) - (CW+1)'($signed(p[i]));
            off[i] = prod_reg[i][CW+TW-1:TW];
            sum[i] = neg_reg[i] ? ((CW+1)'($signed(p_reg[i])) - {1'b0, off[i]})
                                : ((CW+1)'($signed(p_reg[i])) + {1'b0, off[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_ADD);
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= '0;
                    end
                end
                PH_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(TW - 1))
                    begin
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL:  phase_reg <= PH_ADD;
                PH_ADD:  phase_reg <= PH_IDLE;
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            rem_reg <= num_mag;
            den_reg <= num_mag + dq_mag;
            t_reg   <= '0;
            p_reg   <= p;
            for (int i = 0; i < 3; i++)
            begin
                ad_reg[i]  <= dl[i][CW] ? CW'(-dl[i]) : CW'(dl[i]);
                neg_reg[i] <= dl[i][CW];
            end
        end
        if (phase_reg == PH_DIV)
        begin
            // one quotient bit per cycle
            rem_reg <= ge ? MAG_W'(rem2 - {1'b0, den_reg}) : rem2[MAG_W-1:0];
            t_reg   <= {t_reg[TW-2:0], ge};
        end
        if (phase_reg == PH_MUL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= (CW+TW)'(ad_reg[i]) * (CW+TW)'(t_reg);
            end
        end
        if (phase_reg == PH_ADD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                x_reg[i] <= sum[i][CW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;

endmodule

>>> sv/psf_back.sv
// Back end: runs the cuts of one job and emits its pieces into the output register.
`timescale 1ns / 1ps
`include "plane_split_fragment_macros.svh"
module psf_back
    import psf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  psf_job_t   job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] side,
    output vtx_t [2:0] out_v,
    output logic       last_piece
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START1 = 3'd1;
    localparam logic [2:0] ST_WAIT1  = 3'd2;
    localparam logic [2:0] ST_START2 = 3'd3;
    localparam logic [2:0] ST_WAIT2  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    psf_job_t    cur_reg;
    logic [1:0]  k_reg;
    vtx_t        x1_reg, x2_reg;
    logic        out_valid_reg, out_last_reg;
    logic [1:0]  out_side_reg;
    vtx_t [2:0]  out_v_reg;

    logic        load_out, emit, is_last, second;
    logic        cut_start, cut_done;
    logic [1:0]  ip, iq;
    vtx_t        cut_x;

    function automatic vtx_t pick(input sel_t s, input vtx_t o, input vtx_t a, input vtx_t b);
        vtx_t r;
        unique case (s)
            SEL_ORIG: r = o;
            SEL_X1:   r = a;
            SEL_X2:   r = b;
            SEL_ZERO: r = '0;
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign load_out = !out_valid_reg || !out_stall;
    assign emit     = (state_reg == ST_EMIT) && load_out;
    assign is_last  = k_reg == (cur_reg.ctl.npieces - 2'd1);
    assign pop      = job_valid && ((state_reg == ST_IDLE) || (emit && is_last));

    assign second    = state_reg == ST_START2;
    assign cut_start = (state_reg == ST_START1) || second;
    assign ip        = second ? cur_reg.ctl.c2p : cur_reg.ctl.c1p;
    assign iq        = second ? cur_reg.ctl.c2q : cur_reg.ctl.c1q;

    psf_cut u_cut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cut_start),
        .p     (cur_reg.v[ip]),
        .q     (cur_reg.v[iq]),
        .dp    (cur_reg.d[ip]),
        .dq    (cur_reg.d[iq]),
        .done  (cut_done),
        .x     (cut_x)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = job.ctl.ncut1 ? ST_START1 : ST_EMIT;
                end
            end
            ST_START1: state_next = ST_WAIT1;
            ST_WAIT1:
            begin
                if (cut_done)
                begin
                    state_next = cur_reg.ctl.ncut2 ? ST_START2 : ST_EMIT;
                end
            end
            ST_START2: state_next = ST_WAIT2;
            ST_WAIT2:
            begin
                if (cut_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // take the next job straight away after the last piece
                if (emit && is_last)
                begin
                    if (pop)
                    begin
                        state_next = job.ctl.ncut1 ? ST_START1 : ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                k_reg <= '0;
            end
            else if (emit && !is_last)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= job;
        end
        if (state_reg == ST_WAIT1 && cut_done)
        begin
            x1_reg <= cut_x;
        end
        if (state_reg == ST_WAIT2 && cut_done)
        begin
            x2_reg <= cut_x;
        end
        if (emit)
        begin
            out_side_reg <= cur_reg.ctl.pc[k_reg].side;
            out_last_reg <= is_last;
            for (int j = 0; j < 3; j++)
            begin
                out_v_reg[j] <= pick(cur_reg.ctl.pc[k_reg].sel[j], cur_reg.v[j],
                                     x1_reg, x2_reg);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign side       = out_side_reg;
    assign out_v      = out_v_reg;
    assign last_piece = out_last_reg;

    `PSF_ASSERT_IMP(a_emit_in_range, state_reg == ST_EMIT, k_reg < cur_reg.ctl.npieces, "piece index past piece count")
    `PSF_ASSERT_IMP(a_pop_state, pop, (state_reg == ST_IDLE) || (state_reg == ST_EMIT), "job taken while a cut runs")
    `PSF_ASSERT_IMP(a_done_waiting, cut_done, (state_reg == ST_WAIT1) || (state_reg == ST_WAIT2), "cut finished with nobody waiting")

endmodule
